// ===== rtl/core/mtsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_pkg
// Shared types, constants and small arithmetic functions of the two-layer
// perceptron classifier core.
// ----------------------------------------------------------------------------
package mtsc_pkg;

    // Table and vector sizes.
    localparam int C_MAX_IN   = 32;
    localparam int C_MAX_HID  = 32;
    localparam int C_MAX_LAB  = 8;
    localparam int C_FRAC     = 12;

    // Field widths.
    localparam int C_WORD_W   = 16;
    localparam int C_ACC_W    = 40;
    localparam int C_CNT_W    = 6;
    localparam int C_LCNT_W   = 4;
    localparam int C_EXP_W    = 17;
    localparam int C_DEN_W    = 20;
    localparam int C_NUM_W    = 33;
    localparam int C_QUO_W    = 17;
    localparam int C_CIDX_W   = 2;

    localparam logic [17:0] C_LOG2E_Q14 = 18'd23637;

    typedef logic signed [C_WORD_W-1:0] t_word;
    typedef logic signed [C_ACC_W-1:0]  t_acc;

    // Opcodes of an input transaction.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Table selects of a load.
    localparam logic [2:0] SEL_OFFSET = 3'd0;
    localparam logic [2:0] SEL_GAIN   = 3'd1;
    localparam logic [2:0] SEL_HW     = 3'd2;
    localparam logic [2:0] SEL_HB     = 3'd3;
    localparam logic [2:0] SEL_OW     = 3'd4;
    localparam logic [2:0] SEL_OB     = 3'd5;

    // Configuration register indexes.
    localparam logic [C_CIDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [C_CIDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
    localparam logic [C_CIDX_W-1:0] CFG_LABEL_COUNT  = 2'd2;
    localparam logic [C_CIDX_W-1:0] CFG_NORM_FLOOR   = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_NORM_MUL,
        S_NORM_SUM,
        S_ACC_RD,
        S_ACC_MUL,
        S_ACC_WR,
        S_FH_RD,
        S_FH_CALC,
        S_FH_TANH,
        S_OL_BIAS,
        S_OL_INIT,
        S_OL_RD,
        S_OL_MUL,
        S_OL_ADD,
        S_OL_END,
        S_EX_MUL,
        S_EX_CALC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    // Request to the divider.
    typedef struct packed {
        logic                 start;
        logic [C_NUM_W-1:0]   num;
        logic [C_DEN_W-1:0]   den;
    } t_div_req;

    // Saturate a 41-bit value to the word range.
    function automatic t_word sat_word(input logic signed [40:0] v);
        if (v > 41'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -41'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    // Saturate a 41-bit value to the accumulator range.
    function automatic t_acc sat_acc(input logic signed [40:0] v);
        if (v[40] != v[39]) begin
            return v[40] ? {1'b1, {(C_ACC_W-1){1'b0}}} : {1'b0, {(C_ACC_W-1){1'b1}}};
        end else begin
            return v[39:0];
        end
    endfunction

    // tanh samples over |x| in [0,8), step 0.25.
    function automatic logic [12:0] tanh_tab(input logic [5:0] k);
        case (k)
            6'd0:    return 13'd0;
            6'd1:    return 13'd1003;
            6'd2:    return 13'd1893;
            6'd3:    return 13'd2602;
            6'd4:    return 13'd3119;
            6'd5:    return 13'd3475;
            6'd6:    return 13'd3707;
            6'd7:    return 13'd3856;
            6'd8:    return 13'd3949;
            6'd9:    return 13'd4006;
            6'd10:   return 13'd4041;
            6'd11:   return 13'd4063;
            6'd12:   return 13'd4076;
            6'd13:   return 13'd4084;
            6'd14:   return 13'd4089;
            6'd15:   return 13'd4091;
            6'd16:   return 13'd4093;
            6'd17:   return 13'd4094;
            6'd18:   return 13'd4095;
            6'd19:   return 13'd4095;
            default: return 13'd4096;
        endcase
    endfunction

    // 2^-f samples, step 1/16, 1.0 = 65536.
    function automatic logic [16:0] pow2_tab(input logic [4:0] j);
        case (j)
            5'd0:    return 17'd65536;
            5'd1:    return 17'd62757;
            5'd2:    return 17'd60097;
            5'd3:    return 17'd57549;
            5'd4:    return 17'd55109;
            5'd5:    return 17'd52773;
            5'd6:    return 17'd50535;
            5'd7:    return 17'd48393;
            5'd8:    return 17'd46341;
            5'd9:    return 17'd44376;
            5'd10:   return 17'd42495;
            5'd11:   return 17'd40693;
            5'd12:   return 17'd38968;
            5'd13:   return 17'd37316;
            5'd14:   return 17'd35734;
            5'd15:   return 17'd34219;
            default: return 17'd32768;
        endcase
    endfunction

    // tanh with rounded linear interpolation and odd symmetry.
    function automatic t_word tanh_fx(input t_word x);
        logic [16:0] a;
        logic [5:0]  k;
        logic [12:0] t0;
        logic [12:0] d;
        logic [23:0] prod;
        logic [12:0] y;
        a    = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
        k    = {1'b0, a[14:10]};
        t0   = tanh_tab(k);
        d    = tanh_tab(k + 6'd1) - t0;
        prod = 24'(d) * 24'(a[9:0]) + 24'd512;
        y    = a[15] ? 13'd4096 : t0 + 13'(prod[23:10]);
        return x[15] ? -$signed({3'b000, y}) : $signed({3'b000, y});
    endfunction

    // 2^-v for v in Q.12, 1.0 = 65536; zero once the shift reaches 17.
    function automatic logic [C_EXP_W-1:0] pow2_neg(input logic [16:0] v);
        logic [4:0]  k;
        logic [4:0]  j;
        logic [16:0] t0;
        logic [16:0] dif;
        logic [24:0] prod;
        logic [16:0] e;
        k    = v[16:12];
        j    = {1'b0, v[11:8]};
        t0   = pow2_tab(j);
        dif  = t0 - pow2_tab(j + 5'd1);
        prod = 25'(dif) * 25'(v[7:0]) + 25'd128;
        e    = t0 - 17'(prod[24:8]);
        return (k >= 5'd17) ? '0 : e >> k;
    endfunction

endpackage

// ===== rtl/core/mtsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_if
// Channel interfaces of the classifier core: input items, results and
// configuration writes, each with valid and ready.
// ----------------------------------------------------------------------------
interface mtsc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [2:0]  table_select;
    logic [4:0]  row_index;
    logic [4:0]  col_index;
    logic signed [15:0] value;
    logic        last_element;

    modport source (output valid, opcode, table_select, row_index, col_index, value,
                    last_element, input ready);
    modport sink   (input valid, opcode, table_select, row_index, col_index, value,
                    last_element, output ready);
endinterface

interface mtsc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  label_index;
    logic [15:0] probability;
    logic        last_label;

    modport source (output valid, label_index, probability, last_label, input ready);
    modport sink   (input valid, label_index, probability, last_label, output ready);
endinterface

interface mtsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mtsc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_mul
// Shared signed 18x18 multiplier with a registered product, used by every
// multiply-accumulate step of the sequencer.
// ----------------------------------------------------------------------------
module mtsc_mul
    import mtsc_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [17:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [35:0] o_p
);

    logic signed [35:0] r_p;

    // One product per cycle, available on the next cycle.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/mtsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in 17 bits, so 17 steps suffice.
// ----------------------------------------------------------------------------
module mtsc_div
    import mtsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [C_QUO_W-1:0]  o_quo
);

    logic [C_DEN_W-1:0] r_rem, n_rem;
    logic [C_DEN_W-1:0] r_den;
    logic [C_QUO_W-1:0] r_nlo;
    logic [C_QUO_W-1:0] r_quo, n_quo;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [C_DEN_W+1:0] trial;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        trial = {1'b0, r_rem, r_nlo[C_QUO_W-1]} - {2'b00, r_den};
        if (trial[C_DEN_W+1]) begin
            n_rem = {r_rem[C_DEN_W-2:0], r_nlo[C_QUO_W-1]};
            n_quo = {r_quo[C_QUO_W-2:0], 1'b0};
        end else begin
            n_rem = trial[C_DEN_W-1:0];
            n_quo = {r_quo[C_QUO_W-2:0], 1'b1};
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(C_QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {{(C_DEN_W-(C_NUM_W-C_QUO_W)){1'b0}}, i_req.num[C_NUM_W-1:C_QUO_W]};
            r_nlo <= i_req.num[C_QUO_W-1:0];
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_nlo <= {r_nlo[C_QUO_W-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/mlp_tanh_softmax_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_tanh_softmax_classifier_core
// Two-layer perceptron classifier with tanh hidden layer and softmax output.
// ----------------------------------------------------------------------------
// A load transaction is written in its accept cycle. A sample element is
// accepted, normalized and then multiplied into the accumulator of every
// hidden unit in use, all on the shared 18x18 multiplier. The element flagged
// last then runs the hidden finish per hidden unit, the output layer per label
// (bias, then one product per hidden unit), the exponentials per label and,
// per label, a divide (one start state and a wait for the quotient) and the
// output handshake. The input is not ready until all results of the vector
// have been taken. Configuration writes are always accepted and must only come
// while no vector is being finished.
// ----------------------------------------------------------------------------
module mlp_tanh_softmax_classifier_core
    import mtsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtsc_in_if.sink    i_sample,
    mtsc_out_if.source o_result,
    mtsc_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [C_CNT_W-1:0]  r_input_count;
    logic [C_CNT_W-1:0]  r_hidden_count;
    logic [C_LCNT_W-1:0] r_label_count;
    t_word               r_norm_floor;

    // Sequencer state and counters.
    t_state              r_state, n_state;
    logic [C_CNT_W-1:0]  r_elem;
    logic [C_CNT_W-1:0]  r_h;
    logic [C_LCNT_W-1:0] r_l;
    t_word               r_val;
    logic                r_last;
    t_word               r_xn;
    t_word               r_t;
    t_acc                r_s;
    t_word               r_m;
    logic [C_DEN_W-1:0]  r_den;
    logic [15:0]         r_prob;
    logic [C_MAX_HID-1:0] r_acc_vld;
    t_word               r_n2 [C_MAX_LAB];
    logic [C_EXP_W-1:0]  r_ex [C_MAX_LAB];

    // Memories and their registered read data.
    t_word offset_mem [C_MAX_IN];
    t_word gain_mem   [C_MAX_IN];
    t_word hw_mem     [C_MAX_HID*C_MAX_IN];
    t_word hb_mem     [C_MAX_HID];
    t_word ow_mem     [C_MAX_LAB*C_MAX_HID];
    t_word ob_mem     [C_MAX_LAB];
    t_acc  acc_mem    [C_MAX_HID];
    t_word a1_mem     [C_MAX_HID];
    t_word off_q, gain_q, hw_q, hb_q, ow_q, ob_q, a1_q;
    t_acc  acc_q;
    logic  acc_vld_q;
    t_acc  acc_cur;

    // Counts in use, clamped to their legal range.
    logic [C_CNT_W-1:0]  n_in, n_hid;
    logic [C_LCNT_W-1:0] n_lab;

    // Shared multiplier and divider.
    logic signed [17:0]  mul_a, mul_b;
    logic signed [35:0]  mul_p;
    t_div_req            div_req;
    logic                div_done;
    logic [C_QUO_W-1:0]  div_quo;

    // Datapath values.
    logic                in_acc;
    logic                is_load;
    logic                h_end, l_end;
    logic signed [40:0]  rnd_p, sum41;
    t_word               n2_val;
    logic [16:0]         ex_diff;
    logic [32:0]         ex_vtmp;
    logic [C_EXP_W-1:0]  ex_val;
    logic [C_DEN_W-1:0]  den_g;

    assign n_in  = (r_input_count == '0) ? 6'd1 :
                   (r_input_count > 6'(C_MAX_IN)) ? 6'(C_MAX_IN) : r_input_count;
    assign n_hid = (r_hidden_count == '0) ? 6'd1 :
                   (r_hidden_count > 6'(C_MAX_HID)) ? 6'(C_MAX_HID) : r_hidden_count;
    assign n_lab = (r_label_count == '0) ? 4'd1 :
                   (r_label_count > 4'(C_MAX_LAB)) ? 4'(C_MAX_LAB) : r_label_count;

    assign in_acc  = i_sample.valid && i_sample.ready;
    assign is_load = in_acc && (i_sample.opcode == OP_LOAD);
    assign h_end   = (r_h + 6'd1 == n_hid);
    assign l_end   = (r_l + 4'd1 == n_lab);

    // Configuration port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= 6'd32;
            r_hidden_count <= 6'd32;
            r_label_count  <= 4'd8;
            r_norm_floor   <= -16'sd4096;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_INPUT_COUNT:  r_input_count  <= i_cfg.data[C_CNT_W-1:0];
                CFG_HIDDEN_COUNT: r_hidden_count <= i_cfg.data[C_CNT_W-1:0];
                CFG_LABEL_COUNT:  r_label_count  <= i_cfg.data[C_LCNT_W-1:0];
                CFG_NORM_FLOOR:   r_norm_floor   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Table loads.
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            case (i_sample.table_select)
                SEL_OFFSET: offset_mem[i_sample.row_index] <= i_sample.value;
                SEL_GAIN:   gain_mem[i_sample.row_index]   <= i_sample.value;
                SEL_HW:     hw_mem[{i_sample.row_index, i_sample.col_index}] <= i_sample.value;
                SEL_HB:     hb_mem[i_sample.row_index]     <= i_sample.value;
                SEL_OW: begin
                    if (i_sample.row_index < 5'(C_MAX_LAB)) begin
                        ow_mem[{i_sample.row_index[2:0], i_sample.col_index}] <= i_sample.value;
                    end
                end
                SEL_OB: begin
                    if (i_sample.row_index < 5'(C_MAX_LAB)) begin
                        ob_mem[i_sample.row_index[2:0]] <= i_sample.value;
                    end
                end
                default: ;
            endcase
        end
    end

    // Registered reads at the current counters.
    always_ff @(posedge i_clk) begin
        off_q     <= offset_mem[r_elem[4:0]];
        gain_q    <= gain_mem[r_elem[4:0]];
        hw_q      <= hw_mem[{r_h[4:0], r_elem[4:0]}];
        hb_q      <= hb_mem[r_h[4:0]];
        acc_q     <= acc_mem[r_h[4:0]];
        acc_vld_q <= r_acc_vld[r_h[4:0]];
        a1_q      <= a1_mem[r_h[4:0]];
        ow_q      <= ow_mem[{r_l[2:0], r_h[4:0]}];
        ob_q      <= ob_mem[r_l[2:0]];
    end

    // Accumulator value, zero until first written in the vector.
    assign acc_cur = acc_vld_q ? acc_q : '0;

    // Accumulator and activation writes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC_WR) begin
            acc_mem[r_h[4:0]] <= sat_acc(41'(acc_cur) + 41'(mul_p));
        end
        if (r_state == S_FH_TANH) begin
            a1_mem[r_h[4:0]] <= tanh_fx(r_t);
        end
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        ex_diff = 17'($signed({r_m[15], r_m}) - $signed({r_n2[r_l[2:0]][15], r_n2[r_l[2:0]]}));
        case (r_state)
            S_NORM_MUL: begin
                mul_a = 18'($signed(r_val)) - 18'($signed(off_q));
                mul_b = 18'($signed(gain_q));
            end
            S_ACC_MUL: begin
                mul_a = 18'(r_xn);
                mul_b = 18'($signed(hw_q));
            end
            S_OL_MUL: begin
                mul_a = 18'($signed(a1_q));
                mul_b = 18'($signed(ow_q));
            end
            S_EX_MUL: begin
                mul_a = $signed({1'b0, ex_diff});
                mul_b = $signed(C_LOG2E_Q14);
            end
            default: ;
        endcase
    end

    mtsc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Rounding shifts and exponential of the current product or sum.
    always_comb begin
        rnd_p   = (41'(mul_p) + 41'sd2048) >>> C_FRAC;
        sum41   = 41'(sat_acc(41'(acc_cur) + (41'(hb_q) <<< C_FRAC)));
        n2_val  = sat_word((41'(r_s) + 41'sd2048) >>> C_FRAC);
        ex_vtmp = {1'b0, mul_p[31:0]} + 33'd8192;
        ex_val  = pow2_neg(ex_vtmp[30:14]);
        den_g   = (r_den == '0) ? 20'd1 : r_den;
    end

    // Divider request.
    always_comb begin
        div_req.start = (r_state == S_DIV_GO);
        div_req.num   = {r_ex[r_l[2:0]], 16'd0} + 33'(den_g >> 1);
        div_req.den   = den_g;
    end

    mtsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_sample.opcode == OP_SAMPLE) begin
                    if (r_elem < n_in) begin
                        n_state = S_NORM_MUL;
                    end else if (i_sample.last_element) begin
                        n_state = S_FH_RD;
                    end
                end
            end
            S_NORM_MUL: n_state = S_NORM_SUM;
            S_NORM_SUM: n_state = S_ACC_RD;
            S_ACC_RD:   n_state = S_ACC_MUL;
            S_ACC_MUL:  n_state = S_ACC_WR;
            S_ACC_WR: begin
                if (!h_end) begin
                    n_state = S_ACC_RD;
                end else if (r_last) begin
                    n_state = S_FH_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FH_RD:    n_state = S_FH_CALC;
            S_FH_CALC:  n_state = S_FH_TANH;
            S_FH_TANH:  n_state = h_end ? S_OL_BIAS : S_FH_RD;
            S_OL_BIAS:  n_state = S_OL_INIT;
            S_OL_INIT:  n_state = S_OL_RD;
            S_OL_RD:    n_state = S_OL_MUL;
            S_OL_MUL:   n_state = S_OL_ADD;
            S_OL_ADD:   n_state = h_end ? S_OL_END : S_OL_RD;
            S_OL_END:   n_state = l_end ? S_EX_MUL : S_OL_BIAS;
            S_EX_MUL:   n_state = S_EX_CALC;
            S_EX_CALC:  n_state = l_end ? S_DIV_GO : S_EX_MUL;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: n_state = div_done ? S_OUT : S_DIV_WAIT;
            S_OUT: begin
                if (o_result.ready) begin
                    n_state = l_end ? S_IDLE : S_DIV_GO;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Counters and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem    <= '0;
            r_h       <= '0;
            r_l       <= '0;
            r_acc_vld <= '0;
            r_last    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_h <= '0;
                    if (in_acc && i_sample.opcode == OP_SAMPLE) begin
                        r_last <= i_sample.last_element;
                    end
                end
                S_ACC_WR: begin
                    r_acc_vld[r_h[4:0]] <= 1'b1;
                    if (h_end) begin
                        r_h    <= '0;
                        r_elem <= r_elem + 6'd1;
                    end else begin
                        r_h <= r_h + 6'd1;
                    end
                end
                S_FH_TANH: begin
                    if (h_end) begin
                        r_h       <= '0;
                        r_l       <= '0;
                        r_elem    <= '0;
                        r_acc_vld <= '0;
                    end else begin
                        r_h <= r_h + 6'd1;
                    end
                end
                S_OL_INIT: r_h <= '0;
                S_OL_ADD: begin
                    if (!h_end) begin
                        r_h <= r_h + 6'd1;
                    end
                end
                S_OL_END:  r_l <= l_end ? '0 : r_l + 4'd1;
                S_EX_CALC: r_l <= l_end ? '0 : r_l + 4'd1;
                S_OUT: begin
                    if (o_result.ready) begin
                        r_l <= l_end ? '0 : r_l + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_val <= i_sample.value;
            end
            S_NORM_SUM: begin
                r_xn <= sat_word(rnd_p + 41'(r_norm_floor));
            end
            S_FH_CALC: begin
                r_t <= sat_word((sum41 + 41'sd2048) >>> C_FRAC);
            end
            S_FH_TANH: begin
                r_m <= 16'sh8000;
            end
            S_OL_INIT: begin
                r_s <= 40'(ob_q) <<< C_FRAC;
            end
            S_OL_ADD: begin
                r_s <= r_s + 40'(mul_p);
            end
            S_OL_END: begin
                r_n2[r_l[2:0]] <= n2_val;
                if (n2_val > r_m) begin
                    r_m <= n2_val;
                end
                r_den <= '0;
            end
            S_EX_CALC: begin
                r_ex[r_l[2:0]] <= ex_val;
                r_den          <= r_den + 20'(ex_val);
            end
            S_DIV_WAIT: begin
                r_prob <= div_quo[16] ? 16'hFFFF : div_quo[15:0];
            end
            default: ;
        endcase
    end

    // Ports.
    assign i_sample.ready       = (r_state == S_IDLE);
    assign o_result.valid       = (r_state == S_OUT);
    assign o_result.label_index = r_l[2:0];
    assign o_result.probability = r_prob;
    assign o_result.last_label  = l_end;

    // Checks.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_sample.ready)
        else $error("result pending while input ready");

    a_h_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h < n_hid)
        else $error("hidden counter beyond count in use");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OL_BIAS) |-> (r_acc_vld == '0) && (r_elem == '0))
        else $error("accumulators not cleared after hidden finish");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_GO) |=> ##17 div_done)
        else $error("divider did not finish in 18 cycles");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_den != '0))
        else $error("softmax denominator zero");

endmodule
